[rtl/gpioa_pkg.sv]
// Package for the GPIO port adapter: item types, bus access codes,
// register selects and bit positions of the flag and peripheral control registers.
// No dependencies.
package gpioa_pkg;

    // Bus access codes; the fourth code of the field is no access.
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register selects.
    localparam logic [3:0] RS_PORTB    = 4'd0;
    localparam logic [3:0] RS_PORTA    = 4'd1;
    localparam logic [3:0] RS_DDRB     = 4'd2;
    localparam logic [3:0] RS_DDRA     = 4'd3;
    localparam logic [3:0] RS_PCR      = 4'd12;
    localparam logic [3:0] RS_IFR      = 4'd13;
    localparam logic [3:0] RS_IER      = 4'd14;
    localparam logic [3:0] RS_PORTA_NH = 4'd15;

    // Flag register bit positions (bits 6..0 are stored, bit 7 is derived).
    localparam int FLAG_CA2 = 0;
    localparam int FLAG_CA1 = 1;
    localparam int FLAG_CB2 = 3;
    localparam int FLAG_CB1 = 4;
    localparam int FLAG_BITS = 7;

    // Peripheral control register bit positions.
    localparam int PCR_CA1_RISE = 0;
    localparam int PCR_CA2_IND  = 1;
    localparam int PCR_CA2_RISE = 2;
    localparam int PCR_CA2_OUT  = 3;
    localparam int PCR_CB1_RISE = 4;
    localparam int PCR_CB2_IND  = 5;
    localparam int PCR_CB2_RISE = 6;
    localparam int PCR_CB2_OUT  = 7;

    // Handshake line positions in the sampled line vector.
    localparam int LINE_CA1 = 0;
    localparam int LINE_CA2 = 1;
    localparam int LINE_CB1 = 2;
    localparam int LINE_CB2 = 3;
    localparam int LINE_BITS = 4;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] reg_sel;
        logic [7:0] wdata;
        logic [7:0] pa_in;
        logic [7:0] pb_in;
        logic       ca1;
        logic       ca2;
        logic       cb1;
        logic       cb2;
        logic       reset_n;
    } in_item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic [7:0] pa_out;
        logic [7:0] pa_dir;
        logic [7:0] pb_out;
        logic [7:0] pb_dir;
        logic       irq_n;
    } out_item_t;

endpackage

[rtl/gpioa_ifs.sv]
// Valid/ready channel interfaces for the GPIO port adapter.
// Depends on gpioa_pkg for the payload types.
interface gpioa_in_if;
    logic                 valid;
    logic                 ready;
    gpioa_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gpioa_out_if;
    logic                 valid;
    logic                 ready;
    gpioa_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/gpioa_edge.sv]
// Handshake line edge detector: turns enabled edges on the CA and CB control lines into flag set bits.
// Depends on gpioa_pkg for bit positions.
module gpioa_edge (
    input  logic [gpioa_pkg::LINE_BITS-1:0] prev_lines,
    input  logic [gpioa_pkg::LINE_BITS-1:0] now_lines,
    input  logic [7:0]                      pcr,
    input  logic [7:0]                      ier,
    output logic [gpioa_pkg::FLAG_BITS-1:0] set_flags
);

    function automatic logic edge_hit(input logic before_lvl, input logic now_lvl,
                                      input logic rising);
        return rising ? (!before_lvl && now_lvl) : (before_lvl && !now_lvl);
    endfunction

    always_comb
    begin
        set_flags = '0;
        set_flags[gpioa_pkg::FLAG_CA1] = ier[gpioa_pkg::FLAG_CA1]
            && edge_hit(prev_lines[gpioa_pkg::LINE_CA1], now_lines[gpioa_pkg::LINE_CA1],
                        pcr[gpioa_pkg::PCR_CA1_RISE]);
        // A line in output mode never raises its flag.
        set_flags[gpioa_pkg::FLAG_CA2] = ier[gpioa_pkg::FLAG_CA2]
            && !pcr[gpioa_pkg::PCR_CA2_OUT]
            && edge_hit(prev_lines[gpioa_pkg::LINE_CA2], now_lines[gpioa_pkg::LINE_CA2],
                        pcr[gpioa_pkg::PCR_CA2_RISE]);
        set_flags[gpioa_pkg::FLAG_CB1] = ier[gpioa_pkg::FLAG_CB1]
            && edge_hit(prev_lines[gpioa_pkg::LINE_CB1], now_lines[gpioa_pkg::LINE_CB1],
                        pcr[gpioa_pkg::PCR_CB1_RISE]);
        set_flags[gpioa_pkg::FLAG_CB2] = ier[gpioa_pkg::FLAG_CB2]
            && !pcr[gpioa_pkg::PCR_CB2_OUT]
            && edge_hit(prev_lines[gpioa_pkg::LINE_CB2], now_lines[gpioa_pkg::LINE_CB2],
                        pcr[gpioa_pkg::PCR_CB2_RISE]);
    end

endmodule

[rtl/gpioa_regs.sv]
// Register file and bus access logic of the GPIO port adapter; updates on each item while en is high.
// Depends on gpioa_pkg and gpioa_edge.
module gpioa_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  gpioa_pkg::in_item_t  item,
    output gpioa_pkg::out_item_t result
);

    logic [7:0] out_a_reg, out_a_next;
    logic [7:0] out_b_reg, out_b_next;
    logic [7:0] dir_a_reg, dir_a_next;
    logic [7:0] dir_b_reg, dir_b_next;
    logic [7:0] pcr_reg, pcr_next;
    logic [7:0] ier_reg, ier_next;
    logic [gpioa_pkg::FLAG_BITS-1:0] ifr_reg, ifr_next;
    logic [gpioa_pkg::LINE_BITS-1:0] lines_reg, lines_next;

    logic [gpioa_pkg::LINE_BITS-1:0] now_lines;
    logic [gpioa_pkg::FLAG_BITS-1:0] set_flags;
    logic [gpioa_pkg::FLAG_BITS-1:0] flags_edge;
    logic [7:0]                      rdata;
    logic                            access;
    logic                            wr;

    function automatic logic [7:0] port_view(input logic [7:0] outv, input logic [7:0] dir,
                                             input logic [7:0] pins);
        return (outv & dir) | (pins & ~dir);
    endfunction

    assign now_lines = {item.cb2, item.cb1, item.ca2, item.ca1};

    gpioa_edge u_edge (
        .prev_lines (lines_reg),
        .now_lines  (now_lines),
        .pcr        (pcr_reg),
        .ier        (ier_reg),
        .set_flags  (set_flags)
    );

    assign flags_edge = ifr_reg | set_flags;
    assign access     = (item.op == gpioa_pkg::OP_READ) || (item.op == gpioa_pkg::OP_WRITE);
    assign wr         = (item.op == gpioa_pkg::OP_WRITE);

    always_comb
    begin
        out_a_next = out_a_reg;
        out_b_next = out_b_reg;
        dir_a_next = dir_a_reg;
        dir_b_next = dir_b_reg;
        pcr_next   = pcr_reg;
        ier_next   = ier_reg;
        ifr_next   = flags_edge;
        lines_next = now_lines;
        rdata      = 8'h00;

        if (!item.reset_n)
        begin
            out_a_next = 8'h00;
            out_b_next = 8'h00;
            dir_a_next = 8'h00;
            dir_b_next = 8'h00;
            pcr_next   = 8'h00;
            ier_next   = 8'h00;
            ifr_next   = '0;
        end
        else if (access)
        begin
            case (item.reg_sel)
                gpioa_pkg::RS_PORTB:
                begin
                    if (wr)
                        out_b_next = item.wdata;
                    else
                        rdata = port_view(out_b_reg, dir_b_reg, item.pb_in);
                    ifr_next[gpioa_pkg::FLAG_CB1] = 1'b0;
                    if (!pcr_reg[gpioa_pkg::PCR_CB2_IND])
                        ifr_next[gpioa_pkg::FLAG_CB2] = 1'b0;
                end
                gpioa_pkg::RS_PORTA:
                begin
                    if (wr)
                        out_a_next = item.wdata;
                    else
                        rdata = port_view(out_a_reg, dir_a_reg, item.pa_in);
                    ifr_next[gpioa_pkg::FLAG_CA1] = 1'b0;
                    if (!pcr_reg[gpioa_pkg::PCR_CA2_IND])
                        ifr_next[gpioa_pkg::FLAG_CA2] = 1'b0;
                end
                gpioa_pkg::RS_DDRB:
                begin
                    if (wr)
                        dir_b_next = item.wdata;
                    else
                        rdata = dir_b_reg;
                end
                gpioa_pkg::RS_DDRA:
                begin
                    if (wr)
                        dir_a_next = item.wdata;
                    else
                        rdata = dir_a_reg;
                end
                gpioa_pkg::RS_PCR:
                begin
                    if (wr)
                        pcr_next = item.wdata;
                    else
                        rdata = pcr_reg;
                end
                gpioa_pkg::RS_IFR:
                begin
                    // Bit 7 is never stored; it reads as the OR of the others.
                    if (wr)
                        ifr_next = item.wdata[gpioa_pkg::FLAG_BITS-1:0];
                    else
                        rdata = {|flags_edge, flags_edge};
                end
                gpioa_pkg::RS_IER:
                begin
                    if (wr)
                        ier_next = item.wdata;
                    else
                        rdata = ier_reg;
                end
                gpioa_pkg::RS_PORTA_NH:
                begin
                    if (wr)
                        out_a_next = item.wdata;
                    else
                        rdata = port_view(out_a_reg, dir_a_reg, item.pa_in);
                end
                default:
                begin
                    rdata = 8'h00;
                end
            endcase
        end
    end

    always_comb
    begin
        result.rdata  = rdata;
        result.pa_out = out_a_next;
        result.pa_dir = dir_a_next;
        result.pb_out = out_b_next;
        result.pb_dir = dir_b_next;
        result.irq_n  = ~|ifr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_a_reg <= 8'h00;
            out_b_reg <= 8'h00;
            dir_a_reg <= 8'h00;
            dir_b_reg <= 8'h00;
            pcr_reg   <= 8'h00;
            ier_reg   <= 8'h00;
            ifr_reg   <= '0;
            lines_reg <= '0;
        end
        else if (en)
        begin
            out_a_reg <= out_a_next;
            out_b_reg <= out_b_next;
            dir_a_reg <= dir_a_next;
            dir_b_reg <= dir_b_next;
            pcr_reg   <= pcr_next;
            ier_reg   <= ier_next;
            ifr_reg   <= ifr_next;
            lines_reg <= lines_next;
        end
    end

endmodule

[rtl/gpio_port_adapter_with_edge_irq.sv]
// An accepted item is held until the output side is free, then its result is registered.
// Throughput: one item per cycle while the output is not stalled; the input register advances
// into the result register in the same cycle that the register file state is updated.
// Reset (rst_n low, asynchronous) empties both registers and clears all adapter state.
// Depends on gpioa_pkg, gpioa_ifs, gpioa_regs.
module gpio_port_adapter_with_edge_irq (
    input  logic         clk,
    input  logic         rst_n,
    gpioa_in_if.sink     cmd,
    gpioa_out_if.source  res
);

    logic                 in_valid_reg, in_valid_next;
    gpioa_pkg::in_item_t  in_item_reg;
    logic                 out_valid_reg, out_valid_next;
    gpioa_pkg::out_item_t out_item_reg;
    gpioa_pkg::out_item_t result;
    logic                 advance;
    logic                 accept;

    // The held item moves on whenever the result register is empty or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign accept    = cmd.valid && cmd.ready;

    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !res.ready);

    gpioa_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= cmd.data;
        if (advance)
            out_item_reg <= result;
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_item_reg;

endmodule

[rtl/gpioa_checker.sv]
// Port-level checks for the GPIO port adapter, attached to the top level by a bind.
// Depends on gpioa_pkg and gpio_port_adapter_with_edge_irq.
module gpioa_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input logic                 cmd_ready,
    input logic                 res_valid,
    input logic                 res_ready,
    input gpioa_pkg::out_item_t res_data
);

    // No result is offered while reset is held.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result offered during reset");

    // A taken result always frees room for a new item in the same cycle.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> cmd_ready)
        else $error("input stalled while output is being drained");

    // A result that appears from an empty pipeline came from an item accepted into the input register.
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
        else $error("result without a matching item");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

endmodule

bind gpio_port_adapter_with_edge_irq gpioa_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
